@@ rtl/gwrap_pkg.sv @@
// Package for the greedy word wrapper: payload words, controller states,
// command/status structs between controller and datapath, byte constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gwrap_pkg;

    localparam int MAX_WIDTH_DEF = 62;
    localparam int CNT_W         = 6;
    localparam int CHAR_W        = 8;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic [CNT_W-1:0]  LW_RESET = 6'd62;
    localparam logic [CNT_W-1:0]  LL_MAX   = 6'd63;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SP    = 8'h20;

    localparam logic [APB_AW-1:0] ADDR_LINE_WIDTH = 3'd0;

    typedef struct packed {
        logic [CHAR_W-1:0] in_char;
        logic              end_of_text;
    } in_word_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              out_last;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_NL1,
        ST_REP1,
        ST_NL2,
        ST_CHR,
        ST_SP,
        ST_REP2,
        ST_NL3
    } state_t;

    typedef enum logic [1:0] {
        SEL_NL,
        SEL_SP,
        SEL_CHR,
        SEL_REP
    } byte_sel_t;

    // which output phases the accepted word produces
    typedef struct packed {
        logic nl1;
        logic rep1;
        logic nl2;
        logic chr;
        logic sp;
        logic rep2;
        logic nl3;
    } plan_t;

    typedef struct packed {
        logic      load;
        logic      emit;
        byte_sel_t sel;
        logic      last;
    } dp_cmd_t;

    typedef struct packed {
        plan_t plan;
        logic  out_free;
        logic  rep_last;
    } dp_sts_t;

    function automatic logic is_sep(input logic [CHAR_W-1:0] c);
        return c inside {CH_SP, [8'h09:8'h0D]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/gwrap_ctrl.sv @@
// Controller for the greedy word wrapper: steps through the output phases
// of one input word. Depends on gwrap_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gwrap_ctrl
    import gwrap_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_t after_nl1;
        state_t after_rep1;
        state_t after_nl2;
        state_t after_chr;
        state_t after_sp;
        state_t after_rep2;
        state_t first;

        after_rep2 = sts.plan.nl3  ? ST_NL3  : ST_IDLE;
        after_sp   = sts.plan.rep2 ? ST_REP2 : after_rep2;
        after_chr  = sts.plan.sp   ? ST_SP   : after_sp;
        after_nl2  = sts.plan.chr  ? ST_CHR  : after_chr;
        after_rep1 = sts.plan.nl2  ? ST_NL2  : after_nl2;
        after_nl1  = sts.plan.rep1 ? ST_REP1 : after_rep1;
        first      = sts.plan.nl1  ? ST_NL1  : after_nl1;

        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_START;
                end
            end
            ST_START: state_next = first;
            ST_NL1: begin
                if (sts.out_free) state_next = after_nl1;
            end
            ST_REP1: begin
                if (sts.out_free && sts.rep_last) state_next = after_rep1;
            end
            ST_NL2: begin
                if (sts.out_free) state_next = after_nl2;
            end
            ST_CHR: begin
                if (sts.out_free) state_next = after_chr;
            end
            ST_SP: begin
                if (sts.out_free) state_next = after_sp;
            end
            ST_REP2: begin
                if (sts.out_free && sts.rep_last) state_next = after_rep2;
            end
            ST_NL3: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        cmd.load = (state_reg == ST_IDLE) && s_valid;
        cmd.emit = 1'b0;
        cmd.sel  = SEL_NL;
        cmd.last = (state_next == ST_IDLE);
        case (state_reg)
            ST_NL1, ST_NL2, ST_NL3: begin
                cmd.emit = sts.out_free;
                cmd.sel  = SEL_NL;
            end
            ST_REP1, ST_REP2: begin
                cmd.emit = sts.out_free;
                cmd.sel  = SEL_REP;
            end
            ST_CHR: begin
                cmd.emit = sts.out_free;
                cmd.sel  = SEL_CHR;
            end
            ST_SP: begin
                cmd.emit = sts.out_free;
                cmd.sel  = SEL_SP;
            end
            default: begin
                cmd.emit = 1'b0;
                cmd.sel  = SEL_NL;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/gwrap_dp.sv @@
// Datapath for the greedy word wrapper: line/word counters, word buffer,
// per-word output plan and the output register. Depends on gwrap_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gwrap_dp
    import gwrap_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [CNT_W-1:0] line_width,
    input  wire in_word_t         s_data,
    input  wire dp_cmd_t          cmd,
    output dp_sts_t               sts,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_word_t             m_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [CNT_W-1:0] MAX_W = CNT_W'(MAX_WIDTH);

    logic [CHAR_W-1:0] mem [MAX_WIDTH];

    logic [CNT_W-1:0]  ll_reg, ll_next;
    logic [CNT_W-1:0]  wl_reg, wl_next;
    logic              iw_reg, iw_next;
    plan_t             plan_reg, plan_next;
    logic [CHAR_W-1:0] chr_reg;
    logic [CNT_W-1:0]  rep_len_reg;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CHAR_W-1:0] rd_data_reg;
    logic              m_valid_reg, m_valid_next;
    out_word_t         m_data_reg;

    logic [CNT_W-1:0]  w;
    logic              sep, case_a, case_b, case_c, case_d;
    logic              ovf, eo, direct_on, store_on, dir_nl, sp_on;
    logic [CNT_W-1:0]  dir_base, dir_ll, rep_len, ll_end, ll_fin;
    logic [CNT_W:0]    fit_sum, end_sum;

    always_comb begin
        if (line_width == '0) begin
            w = CNT_W'(1);
        end else if (line_width > MAX_W) begin
            w = MAX_W;
        end else begin
            w = line_width;
        end

        sep    = is_sep(s_data.in_char);
        case_a = sep;
        case_b = !sep && !iw_reg && (ll_reg == '0);
        case_c = !sep && iw_reg && (wl_reg == '0);
        case_d = !sep && !case_b && !case_c;

        fit_sum  = {1'b0, ll_reg} + {1'b0, wl_reg} + (CNT_W+1)'(2);
        ovf      = (fit_sum > {1'b0, w}) || (wl_reg >= MAX_W);
        eo       = iw_reg && (wl_reg != '0);
        store_on = case_d && !ovf;
        direct_on = case_b || case_c || (case_d && ovf);

        dir_base = case_d ? wl_reg : ll_reg;
        dir_nl   = (dir_base >= w);
        dir_ll   = (dir_nl ? '0 : dir_base) + CNT_W'(1);

        rep_len  = store_on ? wl_reg + CNT_W'(1) : wl_reg;
        end_sum  = {1'b0, ll_reg} + {1'b0, rep_len} + (CNT_W+1)'(1);
        ll_end   = (end_sum > {1'b0, LL_MAX}) ? LL_MAX : end_sum[CNT_W-1:0];

        sp_on    = (case_a && eo) || (store_on && s_data.end_of_text);
        ll_fin   = sp_on ? ll_end : (direct_on ? dir_ll : ll_reg);

        plan_next.nl1  = case_d && ovf;
        plan_next.rep1 = case_d && ovf && (wl_reg != '0);
        plan_next.nl2  = direct_on && dir_nl;
        plan_next.chr  = direct_on;
        plan_next.sp   = sp_on;
        plan_next.rep2 = sp_on;
        plan_next.nl3  = s_data.end_of_text && (ll_fin != '0);

        ll_next = ll_reg;
        wl_next = wl_reg;
        iw_next = iw_reg;
        if (cmd.load) begin
            if (s_data.end_of_text) begin
                ll_next = '0;
                wl_next = '0;
                iw_next = 1'b0;
            end else begin
                ll_next = ll_fin;
                wl_next = store_on ? wl_reg + CNT_W'(1) : '0;
                iw_next = !sep;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ll_reg   <= '0;
            wl_reg   <= '0;
            iw_reg   <= 1'b0;
            plan_reg <= '0;
        end else begin
            ll_reg <= ll_next;
            wl_reg <= wl_next;
            iw_reg <= iw_next;
            if (cmd.load) begin
                plan_reg <= plan_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            chr_reg     <= s_data.in_char;
            rep_len_reg <= rep_len;
        end
    end

    // replay index; read address holds on the final byte of a replay
    always_comb begin
        idx_next = idx_reg;
        if (cmd.load) begin
            idx_next = '0;
        end else if (cmd.emit && (cmd.sel == SEL_REP) && !sts.rep_last) begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && store_on) begin
            mem[wl_reg[AW-1:0]] <= s_data.in_char;
        end
        rd_data_reg <= mem[idx_next[AW-1:0]];
    end

    always_comb begin
        sts.plan     = plan_reg;
        sts.out_free = !m_valid_reg || m_ready;
        sts.rep_last = ((idx_reg + CNT_W'(1)) == rep_len_reg);
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            case (cmd.sel)
                SEL_NL:  m_data_reg.out_char <= CH_NL;
                SEL_SP:  m_data_reg.out_char <= CH_SP;
                SEL_CHR: m_data_reg.out_char <= chr_reg;
                SEL_REP: m_data_reg.out_char <= rd_data_reg;
                default: m_data_reg.out_char <= CH_NL;
            endcase
            m_data_reg.out_last <= cmd.last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

@@ rtl/greedy_word_wrap_top.sv @@
// Top level of the greedy word wrapper: APB register for the line width,
// controller and datapath. Depends on gwrap_pkg, gwrap_ctrl, gwrap_dp.
//
//   channel   ports                        moves
//   s_        s_valid s_ready s_data       one text byte per word (in_word_t)
//   m_        m_valid m_ready m_data       one wrapped byte per word (out_word_t)
//   apb       psel penable pwrite paddr    line_width at address 0
//
// An input word produces n bytes (0..64): the controller accepts it, plans
// its output phases, then sends one byte per cycle into the output register
// while it is free. Held words replay from the word buffer at one read per cycle.
// m_ready low stalls the byte sequencer; s_ready is high only between words.
// aresetn is synchronous; line_width resets to 62.
`timescale 1ns / 1ps
`default_nettype none

module greedy_word_wrap_top
    import gwrap_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_word_t          s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_word_t              m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    logic [CNT_W-1:0] lw_reg, lw_next;
    logic             lw_sel;
    dp_cmd_t          cmd;
    dp_sts_t          sts;

    assign lw_sel = (paddr[APB_AW-1:2] == ADDR_LINE_WIDTH[APB_AW-1:2]);

    always_comb begin
        lw_next = lw_reg;
        if (psel && penable && pwrite && pready && lw_sel) begin
            lw_next = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_reg <= LW_RESET;
        end else begin
            lw_reg <= lw_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = lw_sel ? {{(APB_DW-CNT_W){1'b0}}, lw_reg} : '0;

    gwrap_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gwrap_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .line_width (lw_reg),
        .s_data     (s_data),
        .cmd        (cmd),
        .sts        (sts),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for greedy_word_wrap_top: streams text bytes in, predicts
// the wrapped byte stream per accepted word and checks each m_ word in order.
// Depends on gwrap_pkg and the greedy_word_wrap_top RTL.

module tb_top;
    import gwrap_pkg::*;

    localparam int MAX_W      = MAX_WIDTH_DEF;
    localparam int RAND_ITEMS = 280;
    localparam int CALM_ITEMS = 60;
    localparam int QUIET_MAX  = 2000;
    localparam int SETTLE     = 12;

    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_word_t          s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b1;
    out_word_t         m_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    greedy_word_wrap_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // wrapper state mirror
    logic [5:0]        cfg_width = LW_RESET;
    logic [CHAR_W-1:0] held_bytes [MAX_W];
    logic [5:0]        held_len  = '0;
    logic [5:0]        line_cols = '0;
    logic              in_token  = 1'b0;
    logic [CHAR_W-1:0] step_q[$];

    in_word_t  text_q[$];
    out_word_t wrap_q[$];
    out_word_t due;

    int bytes_fed    = 0;
    int bytes_taken  = 0;
    int fail_cnt     = 0;
    int quiet_cycles = 0;
    int s_idle_pct   = 0;
    int m_stall_pct  = 0;
    int s_gap        = 0;
    int m_gap        = 0;
    logic s_took     = 1'b0;

    int s_rates[4] = '{0, 5, 15, 35};
    int m_rates[4] = '{0, 2, 6, 15};

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic int unsigned wrap_limit();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_W) return MAX_W;
        return cfg_width;
    endfunction

    function automatic void put_direct(input logic [CHAR_W-1:0] c, input int unsigned lim);
        if (line_cols >= lim) begin
            step_q.push_back(CH_NL);
            line_cols = '0;
        end
        step_q.push_back(c);
        if (line_cols < LL_MAX) line_cols = line_cols + 1'b1;
    endfunction

    function automatic void replay_held();
        for (int i = 0; i < held_len; i++) step_q.push_back(held_bytes[i]);
    endfunction

    function automatic void flush_word();
        int sum;
        if (in_token && held_len != 0) begin
            step_q.push_back(CH_SP);
            replay_held();
            sum = int'(line_cols) + 1 + int'(held_len);
            line_cols = (sum > int'(LL_MAX)) ? LL_MAX : 6'(sum);
        end
        held_len = '0;
        in_token = 1'b0;
    endfunction

    function automatic void wrap_byte(input in_word_t w);
        int unsigned lim;
        out_word_t   o;
        lim = wrap_limit();
        step_q.delete();
        if (is_blank(w.in_char)) begin
            flush_word();
        end else if (!in_token && line_cols == 0) begin
            in_token = 1'b1;
            held_len = '0;
            put_direct(w.in_char, lim);
        end else if (in_token && held_len == 0) begin
            put_direct(w.in_char, lim);
        end else begin
            if (!in_token) begin
                in_token = 1'b1;
                held_len = '0;
            end
            if (int'(line_cols) + int'(held_len) + 2 > lim || held_len >= MAX_W) begin
                // held word no longer fits: close line, replay it on a fresh one
                step_q.push_back(CH_NL);
                replay_held();
                line_cols = held_len;
                held_len  = '0;
                put_direct(w.in_char, lim);
            end else begin
                held_bytes[held_len] = w.in_char;
                held_len = held_len + 1'b1;
            end
        end
        if (w.end_of_text) begin
            flush_word();
            if (line_cols != 0) step_q.push_back(CH_NL);
            line_cols = '0;
            held_len  = '0;
            in_token  = 1'b0;
        end
        foreach (step_q[i]) begin
            o.out_char = step_q[i];
            o.out_last = (i == step_q.size() - 1);
            wrap_q.push_back(o);
        end
    endfunction

    // input driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_gap   <= 0;
        end else if (!s_valid || s_took) begin
            if (s_gap != 0) begin
                s_gap   <= s_gap - 1;
                s_valid <= 1'b0;
            end else if (text_q.size() == 0) begin
                s_valid <= 1'b0;
            end else if ($urandom_range(99) < s_idle_pct) begin
                s_gap   <= $urandom_range(16);
                s_valid <= 1'b0;
            end else begin
                s_valid <= 1'b1;
                s_data  <= text_q.pop_front();
            end
        end
    end

    // output backpressure
    always @(negedge aclk) begin
        if (m_gap != 0) begin
            m_gap   <= m_gap - 1;
            m_ready <= 1'b0;
        end else if (aresetn && $urandom_range(99) < m_stall_pct) begin
            m_gap   <= $urandom_range(16);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor and scoreboard
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_took       <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            s_took <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                wrap_byte(s_data);
                bytes_taken <= bytes_taken + 1;
            end
            if (m_valid && m_ready) begin
                if (wrap_q.size() == 0) begin
                    $error("out_char: expected none, got %02h", m_data.out_char);
                    fail_cnt++;
                end else begin
                    due = wrap_q.pop_front();
                    if (m_data.out_char !== due.out_char) begin
                        $error("out_char: expected %02h, got %02h",
                               due.out_char, m_data.out_char);
                        fail_cnt++;
                    end
                    if (m_data.out_last !== due.out_last) begin
                        $error("out_last: expected %0b, got %0b",
                               due.out_last, m_data.out_last);
                        fail_cnt++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_MAX);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic push_byte(input logic [CHAR_W-1:0] c, input logic eot);
        in_word_t w;
        w.in_char     = c;
        w.end_of_text = eot;
        text_q.push_back(w);
        bytes_fed++;
    endtask

    task automatic wait_quiet();
        do @(negedge aclk);
        while (bytes_taken != bytes_fed || wrap_q.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic set_width(input logic [5:0] w);
        @(negedge aclk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = ADDR_LINE_WIDTH;
        pwdata  = APB_DW'(w);
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        cfg_width = w;
        pwrite    = 1'b0;
        penable   = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        if (prdata[5:0] !== w) begin
            $error("line_width: expected %0d, got %0d", w, prdata[5:0]);
            fail_cnt++;
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] rand_letter();
        logic [CHAR_W-1:0] c;
        do c = CHAR_W'($urandom);
        while (is_blank(c));
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] rand_blank();
        if ($urandom_range(9) < 6) return CH_SP;
        return CHAR_W'($urandom_range(CH_CR, CH_TAB));
    endfunction

    initial begin : stim
        int         fed_at;
        int         n_len;
        int         r;
        logic [5:0] w;
        logic       calm;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // bytes on both sides of the blank range, text ending on a blank
        set_width(LW_RESET);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h09, 1'b0);
        push_byte(8'h08, 1'b0);
        push_byte(8'h0A, 1'b0);
        push_byte(8'h0E, 1'b0);
        push_byte(8'h0B, 1'b0);
        push_byte(8'h1F, 1'b0);
        push_byte(8'h0C, 1'b0);
        push_byte(8'h21, 1'b0);
        push_byte(8'h0D, 1'b0);
        push_byte(8'h20, 1'b1);
        // blanks only: nothing out
        push_byte(8'h20, 1'b0);
        push_byte(8'h09, 1'b1);
        // one-byte text
        push_byte(8'h41, 1'b1);
        wait_quiet();

        // width 1: every byte on its own line
        set_width(6'd1);
        push_byte(8'h61, 1'b0);
        push_byte(8'h62, 1'b0);
        push_byte(8'h20, 1'b0);
        push_byte(8'h63, 1'b1);
        wait_quiet();

        // zero acts as one
        set_width(6'd0);
        push_byte(8'h78, 1'b0);
        push_byte(8'h79, 1'b1);
        wait_quiet();

        // held word overflows the line
        set_width(6'd3);
        push_byte(8'h61, 1'b0);
        push_byte(8'h20, 1'b0);
        push_byte(8'h62, 1'b0);
        push_byte(8'h63, 1'b0);
        push_byte(8'h64, 1'b1);
        wait_quiet();

        // random texts; a text may span phases so width changes land mid-text
        fed_at = bytes_fed;
        do begin
            calm = (bytes_fed - fed_at >= RAND_ITEMS - CALM_ITEMS);
            case ($urandom_range(5))
                0:       w = 6'd1;
                1:       w = 6'd62;
                2:       w = 6'd0;
                3:       w = 6'd63;
                4:       w = 6'($urandom_range(8, 2));
                default: w = 6'($urandom_range(62, 1));
            endcase
            s_idle_pct  = calm ? 0 : s_rates[$urandom_range(3)];
            m_stall_pct = calm ? 0 : m_rates[$urandom_range(3)];
            set_width(w);
            repeat ($urandom_range(14, 3)) begin
                r = $urandom_range(99);
                if (r < 85) n_len = $urandom_range(8, 1);
                else if (r < 95) n_len = $urandom_range(20, 9);
                else n_len = $urandom_range(70, 21);
                repeat (n_len) push_byte(rand_letter(), $urandom_range(99) < 2);
                repeat ($urandom_range(3, 1)) push_byte(rand_blank(), $urandom_range(99) < 2);
            end
            if (calm || $urandom_range(3) == 0)
                push_byte($urandom_range(1) ? rand_letter() : rand_blank(), 1'b1);
            wait_quiet();
        end while (!(calm && bytes_fed - fed_at >= RAND_ITEMS));

        if (fail_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
